// ===== rtl/jxesc_pkg.sv =====
// Shared types, character constants and helpers for the code point escaper.
`default_nettype none
package jxesc_pkg;

   localparam int CP_W     = 21;
   localparam int BYTE_W   = 8;
   localparam int DATA_W   = 32;
   localparam int NDIG_W   = 3;
   localparam int POS_W    = 4;
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = 2;
   localparam int QCNT_W   = 3;

   // Escape mode register values
   localparam logic MODE_JSON = 1'b0;
   localparam logic MODE_XML  = 1'b1;

   // Output characters
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;
   localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
   localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
   localparam logic [BYTE_W-1:0] CH_LOW_X  = 8'h78;
   localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [BYTE_W-1:0] REPL_B0   = 8'hEF;
   localparam logic [BYTE_W-1:0] REPL_B1   = 8'hBF;
   localparam logic [BYTE_W-1:0] REPL_B2   = 8'hBD;

   // Surrogate pair offsets
   localparam logic [15:0] HI_SURR_BASE = 16'hD7C0;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

   // How the back end expands one queued entry
   typedef enum logic [2:0] {
      KIND_PASS,       // one raw byte
      KIND_JSON_U4,    // \uXXXX
      KIND_JSON_PAIR,  // \uHHHH\uLLLL
      KIND_XML_REPL,   // EF BF BD
      KIND_XML_REF     // &#x...;
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [NDIG_W-1:0]     ndig;   // hex digit count for a character reference
      logic [DATA_W-1:0]     data;   // code point or escape words
   } desc_type;

   // Uppercase hex digit for one nibble
   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
      logic [BYTE_W-1:0] res;
      if (nib < 4'd10) begin
         res = 8'h30 + {4'd0, nib};
      end else begin
         res = 8'h37 + {4'd0, nib};
      end
      return res;
   endfunction

endpackage : jxesc_pkg
`default_nettype wire

// ===== rtl/jxesc_ifs.sv =====
// Valid/ready channel interfaces for code points in and escaped bytes out.
`default_nettype none
interface jxesc_req_if;
   import jxesc_pkg::*;
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;

   modport source (output valid, output code_point, input ready);
   modport sink   (input valid, input code_point, output ready);
endinterface : jxesc_req_if

interface jxesc_rsp_if;
   import jxesc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface : jxesc_rsp_if
`default_nettype wire

// ===== rtl/jxesc_front.sv =====
// Front end: holds the mode register and classifies each code point into a queue entry.
`default_nettype none
module jxesc_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_en,
   input  wire logic               csr_write_data,
   jxesc_req_if.sink               req_bus,
   output logic                    push_valid,
   output jxesc_pkg::desc_type     push_data,
   input  wire logic               push_ready
);
   import jxesc_pkg::*;

   logic            mode_ff;
   logic [CP_W-1:0] cp;
   logic            json_esc;
   logic            xml_nonchar;
   logic            xml_escapee;
   logic [10:0]     cp_hi;
   logic [15:0]     hi_word;
   logic [15:0]     lo_word;
   logic [NDIG_W-1:0] ndig;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_JSON;
      end else if (csr_write_en) begin
         mode_ff <= csr_write_data;
      end
   end

   assign cp = req_bus.code_point;

   // Classify the code point
   assign json_esc = (cp < 21'h20) || (cp == 21'h22) || (cp == 21'h5C) ||
                     (cp == 21'h5B) || (cp == 21'h5D) || (cp > 21'h7F);

   assign xml_nonchar = (cp > 21'h10FFFF) || (cp == 21'hFFFE) || (cp == 21'hFFFF) ||
                        (cp == 21'hFFFD) || ((cp >= 21'hD800) && (cp <= 21'hDFFF)) ||
                        (cp < 21'h09) || (cp == 21'h0B) || (cp == 21'h0C) ||
                        ((cp >= 21'h0E) && (cp < 21'h20));

   assign xml_escapee = (cp == 21'h0D) || (cp == 21'h0A) || (cp == 21'h09) ||
                        (cp == 21'h3C) || (cp == 21'h3E) || (cp == 21'h26) ||
                        (cp == 21'h27) || (cp > 21'h7F);

   // Surrogate pair words
   assign cp_hi   = cp[CP_W-1:10];
   assign hi_word = HI_SURR_BASE + {5'd0, cp_hi};
   assign lo_word = LO_SURR_BASE + {6'd0, cp[9:0]};

   // Count significant hex digits, at least one
   always_comb begin
      priority if (cp[20])           ndig = 3'd6;
      else if (cp[19:16] != 4'd0)    ndig = 3'd5;
      else if (cp[15:12] != 4'd0)    ndig = 3'd4;
      else if (cp[11:8]  != 4'd0)    ndig = 3'd3;
      else if (cp[7:4]   != 4'd0)    ndig = 3'd2;
      else                           ndig = 3'd1;
   end

   // Build the queue entry
   always_comb begin
      push_data.ndig = ndig;
      push_data.data = {{(DATA_W-CP_W){1'b0}}, cp};
      if (mode_ff == MODE_JSON) begin
         if (!json_esc) begin
            push_data.kind = KIND_PASS;
         end else if (cp > 21'hFFFF) begin
            push_data.kind = KIND_JSON_PAIR;
            push_data.data = {hi_word, lo_word};
         end else begin
            push_data.kind = KIND_JSON_U4;
         end
      end else begin
         priority if (xml_nonchar) begin
            push_data.kind = KIND_XML_REPL;
         end else if (xml_escapee) begin
            push_data.kind = KIND_XML_REF;
         end else begin
            push_data.kind = KIND_PASS;
         end
      end
   end

   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

endmodule : jxesc_front
`default_nettype wire

// ===== rtl/jxesc_queue.sv =====
// Small entry queue that decouples classification from byte expansion.
`default_nettype none
module jxesc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire jxesc_pkg::desc_type push_data,
   output logic                    push_ready,
   output logic                    pop_valid,
   output jxesc_pkg::desc_type     pop_data,
   input  wire logic               pop_ready
);
   import jxesc_pkg::*;

   desc_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : jxesc_queue
`default_nettype wire

// ===== rtl/jxesc_back.sv =====
// Back end: expands the head queue entry into escaped bytes, one per cycle while rsp_bus is not stalled.
`default_nettype none
module jxesc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire jxesc_pkg::desc_type head_data,
   output logic                    head_pop,
   jxesc_rsp_if.source             rsp_bus
);
   import jxesc_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic              advance;
   logic [BYTE_W-1:0] byte_c;
   logic              last_c;
   logic              second_half;
   logic [2:0]        sub_pos;
   logic [15:0]       word;
   logic [3:0]        u4_nib;
   logic [POS_W-1:0]  semi_pos;
   logic [POS_W-1:0]  dig_off;
   logic [2:0]        dig_idx;
   logic [3:0]        ref_nib;

   // Escape word and position inside one \uXXXX group
   assign second_half = (pos_ff >= POS_W'(6));
   assign sub_pos     = second_half ? 3'(pos_ff - POS_W'(6)) : pos_ff[2:0];
   assign word        = (head_data.kind == KIND_JSON_PAIR && !second_half) ?
                        head_data.data[31:16] : head_data.data[15:0];

   always_comb begin
      unique case (sub_pos)
         3'd2:    u4_nib = word[15:12];
         3'd3:    u4_nib = word[11:8];
         3'd4:    u4_nib = word[7:4];
         default: u4_nib = word[3:0];
      endcase
   end

   // Digit selection for a character reference
   assign semi_pos = {1'b0, head_data.ndig} + POS_W'(3);
   assign dig_off  = {1'b0, head_data.ndig} + POS_W'(2) - pos_ff;
   assign dig_idx  = dig_off[2:0];

   always_comb begin
      unique case (dig_idx)
         3'd0:    ref_nib = head_data.data[3:0];
         3'd1:    ref_nib = head_data.data[7:4];
         3'd2:    ref_nib = head_data.data[11:8];
         3'd3:    ref_nib = head_data.data[15:12];
         3'd4:    ref_nib = head_data.data[19:16];
         default: ref_nib = {3'd0, head_data.data[20]};
      endcase
   end

   // Pick the byte for the current position
   always_comb begin
      byte_c = head_data.data[BYTE_W-1:0];
      last_c = 1'b1;
      unique case (head_data.kind)
         KIND_PASS: begin
            byte_c = head_data.data[BYTE_W-1:0];
            last_c = 1'b1;
         end
         KIND_JSON_U4, KIND_JSON_PAIR: begin
            priority case (sub_pos)
               3'd0:    byte_c = CH_BSLASH;
               3'd1:    byte_c = CH_LOW_U;
               default: byte_c = hex_char(u4_nib);
            endcase
            last_c = (head_data.kind == KIND_JSON_PAIR) ? (pos_ff == POS_W'(11)) :
                                                          (pos_ff == POS_W'(5));
         end
         KIND_XML_REPL: begin
            priority case (pos_ff)
               POS_W'(0): byte_c = REPL_B0;
               POS_W'(1): byte_c = REPL_B1;
               default:   byte_c = REPL_B2;
            endcase
            last_c = (pos_ff == POS_W'(2));
         end
         KIND_XML_REF: begin
            priority if (pos_ff == POS_W'(0)) byte_c = CH_AMP;
            else if (pos_ff == POS_W'(1))     byte_c = CH_HASH;
            else if (pos_ff == POS_W'(2))     byte_c = CH_LOW_X;
            else if (pos_ff == semi_pos)      byte_c = CH_SEMI;
            else                              byte_c = hex_char(ref_nib);
            last_c = (pos_ff == semi_pos);
         end
         default: begin
            byte_c = head_data.data[BYTE_W-1:0];
            last_c = 1'b1;
         end
      endcase
   end

   // Emit a beat whenever the output register is free or being drained
   assign advance  = head_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign head_pop = advance && last_c;

   always_comb begin
      pos_in = pos_ff;
      if (advance) begin
         pos_in = last_c ? '0 : pos_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff <= byte_c;
         rsp_last_ff <= last_c;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_byte  = rsp_byte_ff;
   assign rsp_bus.last_byte = rsp_last_ff;

endmodule : jxesc_back
`default_nettype wire

// ===== rtl/json_xml_code_point_escaper_unit.sv =====
// Top level of the JSON / XML code point escaper.
// The block takes one code point per beat on req_bus and returns its escaped text on
// rsp_bus as a burst of 1 to 12 byte beats, the final one flagged by last_byte.
// csr_write_data selects the mode (0 JSON string escaping, 1 XML attribute escaping);
// write it only while the block is idle. A code point is accepted in any cycle that the
// four-entry queue behind the classifier has room, so plain ASCII streams at one code
// point per cycle while rsp_bus is not stalled. The byte expander emits one byte per
// cycle while rsp_bus is not stalled: 1 byte for a pass-through, 3 for the XML replacement
// character, 5 to 10 for an XML character reference, 6 for a JSON \u escape and 12 for a
// surrogate pair. The first byte goes through the queue and then the output payload register.
`default_nettype none
module json_xml_code_point_escaper_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_write_en,
   input  wire logic  csr_write_data,
   jxesc_req_if.sink  req_bus,
   jxesc_rsp_if.source rsp_bus
);
   import jxesc_pkg::*;

   logic     push_valid;
   logic     push_ready;
   desc_type push_data;
   logic     head_valid;
   logic     head_pop;
   desc_type head_data;

   // Classify incoming code points
   jxesc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .push_valid     (push_valid),
      .push_data      (push_data),
      .push_ready     (push_ready)
   );

   // Buffer classified entries
   jxesc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (head_valid),
      .pop_data   (head_data),
      .pop_ready  (head_pop)
   );

   // Expand entries into byte beats
   jxesc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule : json_xml_code_point_escaper_unit
`default_nettype wire

// ===== verif/tb_json_xml_code_point_escaper_unit.sv =====
// Testbench for the JSON / XML code point escaper: directed and random code points.
`timescale 1ns / 100ps
module tb_json_xml_code_point_escaper_unit;
   import jxesc_pkg::*;

   // ASCII used when building the expected escaped text
   localparam logic [7:0] ASC_BSLASH = 8'h5C;
   localparam logic [7:0] ASC_U      = 8'h75;
   localparam logic [7:0] ASC_AMP    = 8'h26;
   localparam logic [7:0] ASC_HASH   = 8'h23;
   localparam logic [7:0] ASC_X      = 8'h78;
   localparam logic [7:0] ASC_SEMI   = 8'h3B;
   localparam logic [7:0] ASC_QUOTE  = 8'h22;
   localparam logic [7:0] ASC_APOS   = 8'h27;
   localparam logic [7:0] ASC_LT     = 8'h3C;
   localparam logic [7:0] ASC_GT     = 8'h3E;
   localparam logic [7:0] ASC_LBRK   = 8'h5B;
   localparam logic [7:0] ASC_RBRK   = 8'h5D;
   localparam int         TAIL_CYCLES = 16;

   typedef struct packed {
      logic [BYTE_W-1:0] code;
      logic              last;
   } esc_beat_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   jxesc_req_if req_bus ();
   jxesc_rsp_if rsp_bus ();

   json_xml_code_point_escaper_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus)
   );

   esc_beat_type      pending_bytes[$];  // escaped bytes still owed by the block
   logic [BYTE_W-1:0] burst_bytes[$];    // scratch for one code point's escape
   logic              esc_mode;          // our copy of the mode register
   int                err_count;
   int                send_gap_pct;
   int                rsp_stall_pct;
   int                rsp_stall_left;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Gap length: mostly short, now and then long
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 80) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + {4'd0, nib};
      end
      return 8'h41 + {4'd0, nib} - 8'd10;
   endfunction

   // Append \uXXXX for one 16-bit word
   function automatic void add_u_escape(input logic [15:0] w);
      burst_bytes.push_back(ASC_BSLASH);
      burst_bytes.push_back(ASC_U);
      for (int s = 12; s >= 0; s -= 4) begin
         burst_bytes.push_back(hex_ascii(w[s +: 4]));
      end
   endfunction

   function automatic bit is_xml_nonchar(input logic [CP_W-1:0] cp);
      return cp > 21'h10FFFF || cp == 21'hFFFD || cp == 21'hFFFE || cp == 21'hFFFF ||
             (cp >= 21'hD800 && cp <= 21'hDFFF) || cp < 21'h09 ||
             cp == 21'h0B || cp == 21'h0C || (cp >= 21'h0E && cp < 21'h20);
   endfunction

   function automatic bit is_xml_escapee(input logic [CP_W-1:0] cp);
      return cp == 21'h09 || cp == 21'h0A || cp == 21'h0D || cp == {13'd0, ASC_LT} ||
             cp == {13'd0, ASC_GT} || cp == {13'd0, ASC_AMP} ||
             cp == {13'd0, ASC_APOS} || cp > 21'h7F;
   endfunction

   // Work out the escaped bytes of one code point and queue them
   function automatic void predict_escape(input logic [CP_W-1:0] cp);
      logic [23:0] wide;
      logic [15:0] hi_word;
      logic [15:0] lo_word;
      int          sh;
      wide = {3'd0, cp};
      burst_bytes.delete();
      if (esc_mode == MODE_JSON) begin
         if (cp < 21'h20 || cp == {13'd0, ASC_QUOTE} || cp == {13'd0, ASC_BSLASH} ||
             cp == {13'd0, ASC_LBRK} || cp == {13'd0, ASC_RBRK} || cp > 21'h7F) begin
            if (cp > 21'hFFFF) begin
               hi_word = 16'hD7C0 + 16'(cp >> 10);
               lo_word = 16'hDC00 + {6'd0, cp[9:0]};
               add_u_escape(hi_word);
               add_u_escape(lo_word);
            end else begin
               add_u_escape(cp[15:0]);
            end
         end else begin
            burst_bytes.push_back(cp[7:0]);
         end
      end else begin
         if (is_xml_nonchar(cp)) begin
            burst_bytes.push_back(8'hEF);
            burst_bytes.push_back(8'hBF);
            burst_bytes.push_back(8'hBD);
         end else if (is_xml_escapee(cp)) begin
            burst_bytes.push_back(ASC_AMP);
            burst_bytes.push_back(ASC_HASH);
            burst_bytes.push_back(ASC_X);
            // drop leading zero digits, keep at least one
            sh = 20;
            while (sh > 0 && wide[sh +: 4] == 4'd0) begin
               sh -= 4;
            end
            for (; sh >= 0; sh -= 4) begin
               burst_bytes.push_back(hex_ascii(wide[sh +: 4]));
            end
            burst_bytes.push_back(ASC_SEMI);
         end else begin
            burst_bytes.push_back(cp[7:0]);
         end
      end
      foreach (burst_bytes[i]) begin
         pending_bytes.push_back('{code: burst_bytes[i], last: (i == burst_bytes.size() - 1)});
      end
   endfunction

   // Random code point, weighted toward the interesting regions
   function automatic logic [CP_W-1:0] rand_code_point();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return 21'($urandom_range(21'h20, 21'h7E));
      end else if (r < 60) begin
         return ($urandom_range(0, 5) == 0) ? 21'h7F : 21'($urandom_range(0, 21'h1F));
      end else if (r < 70) begin
         return 21'($urandom_range(21'h80, 21'hFFFF));
      end else if (r < 75) begin
         return 21'($urandom_range(21'hD800, 21'hDFFF));
      end else if (r < 80) begin
         return 21'($urandom_range(21'hFFFC, 21'hFFFF));
      end else if (r < 92) begin
         return 21'($urandom_range(21'h10000, 21'h10FFFF));
      end
      return 21'($urandom_range(0, 21'h1FFFFF));
   endfunction

   // Drive one code point beat and hold it until accepted
   task automatic send_code_point(input logic [CP_W-1:0] cp);
      int gap;
      gap = (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.code_point <= cp;
      do @(posedge clock); while (!req_bus.ready);
      predict_escape(cp);
   endtask

   // Drop valid and wait until every owed byte has come back
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic write_escape_mode(input logic m);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      esc_mode = m;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // JSON escapes straight out of reset, mode left at its reset value
   task automatic test_json_escapes();
      logic [CP_W-1:0] cps[$];
      cps = '{21'h00, 21'h1F, 21'h20, 21'h22, 21'h5C, 21'h5B, 21'h5D, 21'h41,
              21'h7F, 21'h80, 21'hFFFF, 21'h10000, 21'h10FFFF, 21'h1FFFFF};
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      foreach (cps[i]) send_code_point(cps[i]);
      wait_idle();
   endtask

   // XML replacement characters, character references and pass-through
   task automatic test_xml_escapes();
      logic [CP_W-1:0] cps[$];
      cps = '{21'h00, 21'h09, 21'h0A, 21'h0B, 21'h0D, 21'h1F, 21'h3C, 21'h3E,
              21'h26, 21'h27, 21'h22, 21'h7F, 21'h80, 21'hD800, 21'hDFFF, 21'hFFFD,
              21'hFFFE, 21'h10FFFF, 21'h110000, 21'h1FFFFF, 21'h100};
      write_escape_mode(MODE_XML);
      send_gap_pct  = 30;
      rsp_stall_pct = 30;
      foreach (cps[i]) send_code_point(cps[i]);
      wait_idle();
   endtask

   // One mode setting, random text, a full drain halfway through
   task automatic test_random_text(input logic m, input int n, input int gap_pct,
                                   input int stall_pct);
      write_escape_mode(m);
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) wait_idle();
         send_code_point(rand_code_point());
      end
      wait_idle();
   endtask

   // Stall the byte side at random
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left = pick_gap() - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each byte beat with the oldest owed byte
   always @(posedge clock) begin
      esc_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none actual %h last %b", $time,
                     rsp_bus.out_byte, rsp_bus.last_byte);
            err_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_bus.out_byte !== want.code) begin
               $display("%0t: out_byte mismatch, expected %h actual %h", $time,
                        want.code, rsp_bus.out_byte);
               err_count++;
            end
            if (rsp_bus.last_byte !== want.last) begin
               $display("%0t: last_byte mismatch, expected %b actual %b", $time,
                        want.last, rsp_bus.last_byte);
               err_count++;
            end
         end
      end
   end

   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_write_data     = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.code_point = '0;
      rsp_bus.ready      = 1'b0;
      esc_mode           = MODE_JSON;
      err_count          = 0;
      send_gap_pct       = 0;
      rsp_stall_pct      = 0;
      rsp_stall_left     = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_json_escapes();
      test_xml_escapes();
      test_random_text(MODE_JSON, 22, 20, 20);
      test_random_text(MODE_XML, 22, 0, 0);
      test_random_text(MODE_JSON, 22, 40, 40);
      test_random_text(MODE_XML, 22, 25, 50);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && pending_bytes.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== json_xml_code_point_escaper_unit.f =====
rtl/jxesc_pkg.sv
rtl/jxesc_ifs.sv
rtl/jxesc_front.sv
rtl/jxesc_queue.sv
rtl/jxesc_back.sv
rtl/json_xml_code_point_escaper_unit.sv
verif/tb_json_xml_code_point_escaper_unit.sv
